/* rtl/core/hawc_pkg.sv */
package hawc_pkg;

    localparam int COORD_BITS = 20;

    localparam int SHW_BITS      = 19;
    localparam int KAPPA_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 19;

    localparam logic [SHW_BITS-1:0]   SHW_RESET   = 19'd6400;
    localparam logic [KAPPA_BITS-1:0] KAPPA_RESET = 16'd1720;
    localparam logic                  FOLD_RESET  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SEARCH_HALF_WIDTH = 2'd0,
        CFG_KAPPA             = 2'd1,
        CFG_FOLD_ENABLE       = 2'd2
    } cfg_reg_t;

    localparam int MAG_BITS      = 19;
    localparam int DEN_BITS      = 20;
    localparam int RATIO_BITS    = 17;
    localparam int SQ_BITS       = 2 * MAG_BITS;
    localparam int D2_BITS       = SQ_BITS + 1;
    localparam int DIST_RAD_BITS = 52;
    localparam int DIST_BITS     = DIST_RAD_BITS / 2;
    localparam int S_BITS        = 27;
    localparam int INV_BITS      = 31;
    localparam int INV_RAD_BITS  = 32;
    localparam int W_BITS        = INV_RAD_BITS / 2;
    localparam int T_BITS        = 14;
    localparam int M_BITS        = 17;
    localparam int A16_BITS      = 19;

    localparam logic [T_BITS-1:0]       POLY_C1        = 14'd12865;
    localparam logic [15:0]             POLY_C2        = 16'd64337;
    localparam logic [A16_BITS-1:0]     QTR_PI_Q16     = 19'd51472;
    localparam logic [A16_BITS-1:0]     THR_QTR_PI_Q16 = 19'd154416;
    localparam logic signed [15:0]      PI_Q13         = 16'sd25736;
    localparam logic [W_BITS-1:0]       WEIGHT_MAX     = 16'd32767;
    localparam logic [RATIO_BITS-1:0]   RATIO_MAX      = 17'd65536;
    localparam logic [S_BITS-1:0]       INV_NUM        = 27'd64;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_z;
        logic signed [COORD_BITS-1:0] hit_x;
        logic signed [COORD_BITS-1:0] hit_z;
    } hit_t;

    typedef struct packed {
        logic               contributes;
        logic signed [15:0] angle;
        logic signed [15:0] weight;
    } res_t;

endpackage

/* rtl/core/hit_angle_weight_contribution.sv */
// Hit angle and weight about a projected vertex. Each beat on hit_data carries one hit and
// the vertex; each beat on res_data gives contributes, the approximate atan2 angle (Q3.13)
// and the weight 1/sqrt(distance+kappa) (Q1.15, signed when folded). One beat is taken
// every clock cycle while the pipeline is not held; a result passes through a chain
// of bit-per-stage units: a 17-stage ratio divider, a 26-stage distance root, a 31-stage
// reciprocal divider and a 16-stage weight root, plus front, polynomial, sum and output
// registers. The whole pipeline holds while res_stall is high and a result waits.
// Configuration writes are always ready and must only be issued while the block is empty.
module hit_angle_weight_contribution
    import hawc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     hit_valid,
    output logic                     hit_stall,
    input  hit_t                     hit_data,
    output logic                     res_valid,
    input  logic                     res_stall,
    output res_t                     res_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int CMP_W  = (DIFF_W > SHW_BITS) ? DIFF_W : SHW_BITS;

    typedef struct packed {
        logic               contributes;
        logic               xneg;
        logic               zneg;
        logic               rneg;
        logic [D2_BITS-1:0] d2;
    } ang_side_t;

    typedef struct packed {
        logic               contributes;
        logic signed [15:0] angle;
    } wt_side_t;

    logic [SHW_BITS-1:0]   shw_reg;
    logic [KAPPA_BITS-1:0] kappa_reg;
    logic                  fold_reg;
    logic                  advance;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shw_reg   <= SHW_RESET;
            kappa_reg <= KAPPA_RESET;
            fold_reg  <= FOLD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SEARCH_HALF_WIDTH: shw_reg   <= cfg_data[SHW_BITS-1:0];
                CFG_KAPPA:             kappa_reg <= cfg_data[KAPPA_BITS-1:0];
                CFG_FOLD_ENABLE:       fold_reg  <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    logic res_valid_reg;
    res_t res_data_reg;

    assign advance   = !res_valid_reg || !res_stall;
    assign hit_stall = !advance;

    // front: difference, magnitude, window, squares
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] a_dx_reg, a_dz_reg;
    logic                     b_valid_reg;
    logic [DIFF_W-1:0]        b_ax_reg, b_az_reg;
    logic                     b_xneg_reg, b_zneg_reg;
    logic                     c_valid_reg, c_contrib_reg, c_xneg_reg, c_zneg_reg;
    logic [MAG_BITS-1:0]      c_ax_reg, c_az_reg;
    logic                     d_valid_reg, d_contrib_reg, d_xneg_reg, d_zneg_reg, d_rneg_reg;
    logic [DEN_BITS-1:0]      d_nmag_reg, d_den_reg;
    logic [SQ_BITS-1:0]       d_sqx_reg, d_sqz_reg;
    logic                     e_valid_reg;
    logic [DEN_BITS-1:0]      e_nmag_reg, e_den_reg;
    ang_side_t                e_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= hit_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_dx_reg <= DIFF_W'(hit_data.hit_x) - DIFF_W'(hit_data.vertex_x);
            a_dz_reg <= DIFF_W'(hit_data.hit_z) - DIFF_W'(hit_data.vertex_z);

            b_ax_reg   <= a_dx_reg[DIFF_W-1] ? DIFF_W'(-a_dx_reg) : DIFF_W'(a_dx_reg);
            b_az_reg   <= a_dz_reg[DIFF_W-1] ? DIFF_W'(-a_dz_reg) : DIFF_W'(a_dz_reg);
            b_xneg_reg <= a_dx_reg[DIFF_W-1];
            b_zneg_reg <= a_dz_reg[DIFF_W-1];

            c_contrib_reg <= (CMP_W'(b_ax_reg) <= CMP_W'(shw_reg))
                          && (CMP_W'(b_az_reg) <= CMP_W'(shw_reg))
                          && !(b_ax_reg == '0 && b_az_reg == '0);
            c_ax_reg      <= MAG_BITS'(b_ax_reg);
            c_az_reg      <= MAG_BITS'(b_az_reg);
            c_xneg_reg    <= b_xneg_reg;
            c_zneg_reg    <= b_zneg_reg;

            d_contrib_reg <= c_contrib_reg;
            d_xneg_reg    <= c_xneg_reg;
            d_zneg_reg    <= c_zneg_reg;
            d_rneg_reg    <= c_xneg_reg ? (c_az_reg < c_ax_reg) : (c_ax_reg < c_az_reg);
            d_nmag_reg    <= (c_ax_reg >= c_az_reg) ? DEN_BITS'(c_ax_reg - c_az_reg)
                                                    : DEN_BITS'(c_az_reg - c_ax_reg);
            d_den_reg     <= DEN_BITS'(c_ax_reg) + DEN_BITS'(c_az_reg);
            d_sqx_reg     <= SQ_BITS'(c_ax_reg) * SQ_BITS'(c_ax_reg);
            d_sqz_reg     <= SQ_BITS'(c_az_reg) * SQ_BITS'(c_az_reg);

            e_nmag_reg              <= d_nmag_reg;
            e_den_reg               <= d_den_reg;
            e_side_reg.contributes  <= d_contrib_reg;
            e_side_reg.xneg         <= d_xneg_reg;
            e_side_reg.zneg         <= d_zneg_reg;
            e_side_reg.rneg         <= d_rneg_reg;
            e_side_reg.d2           <= D2_BITS'(d_sqx_reg) + D2_BITS'(d_sqz_reg);
        end
    end

    // ratio divider
    logic                  div_valid;
    logic [RATIO_BITS-1:0] div_quo;
    ang_side_t             div_side;

    hawc_div_pipe #(
        .DW(DEN_BITS),
        .QW(RATIO_BITS),
        .SW($bits(ang_side_t))
    ) u_ratio_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (e_valid_reg),
        .in_num   (e_nmag_reg),
        .in_den   (e_den_reg),
        .in_side  (e_side_reg),
        .out_valid(div_valid),
        .out_quo  (div_quo),
        .out_side (div_side)
    );

    // cubic polynomial and quadrant base
    logic                    p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic [RATIO_BITS-1:0]   p1_a_reg, p2_a_reg;
    logic [2*RATIO_BITS-1:0] p1_aa_reg;
    logic [T_BITS-1:0]       p2_t_reg;
    logic [M_BITS-1:0]       p3_m_reg;
    ang_side_t               p1_side_reg, p2_side_reg, p3_side_reg;
    logic [D2_BITS-1:0]      p4_d2_reg;
    wt_side_t                p4_side_reg;

    logic [29:0]                t_prod;
    logic [15:0]                c_minus_t;
    logic [32:0]                m_prod;
    logic signed [A16_BITS-1:0] a16_base;
    logic signed [A16_BITS-1:0] a16_sum;
    logic signed [A16_BITS-1:0] a16_clamp;
    logic signed [A16_BITS-1:0] a16_round;
    logic signed [15:0]         ang_mag;

    assign t_prod    = 30'(POLY_C1) * 30'(p1_aa_reg[2*RATIO_BITS-1:16]);
    assign c_minus_t = POLY_C2 - 16'(p2_t_reg);
    assign m_prod    = 33'(c_minus_t) * 33'(p2_a_reg);
    assign a16_base  = p3_side_reg.xneg ? THR_QTR_PI_Q16 : QTR_PI_Q16;
    assign a16_sum   = p3_side_reg.rneg ? a16_base + A16_BITS'(p3_m_reg)
                                        : a16_base - A16_BITS'(p3_m_reg);
    assign a16_clamp = a16_sum[A16_BITS-1] ? '0 : a16_sum;
    assign a16_round = (a16_clamp + A16_BITS'(4)) >>> 3;
    assign ang_mag   = a16_round[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= div_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_a_reg    <= div_quo;
            p1_aa_reg   <= (2*RATIO_BITS)'(div_quo) * (2*RATIO_BITS)'(div_quo);
            p1_side_reg <= div_side;

            p2_a_reg    <= p1_a_reg;
            p2_t_reg    <= t_prod[29:16];
            p2_side_reg <= p1_side_reg;

            p3_m_reg    <= m_prod[32:16];
            p3_side_reg <= p2_side_reg;

            p4_d2_reg               <= p3_side_reg.d2;
            p4_side_reg.contributes <= p3_side_reg.contributes;
            p4_side_reg.angle       <= p3_side_reg.zneg ? -ang_mag : ang_mag;
        end
    end

    // distance root
    logic                 dist_valid;
    logic [DIST_BITS-1:0] dist_root;
    wt_side_t             dist_side;

    hawc_sqrt_pipe #(
        .RW(DIST_RAD_BITS),
        .SW($bits(wt_side_t))
    ) u_dist_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (p4_valid_reg),
        .in_rad   ({1'b0, p4_d2_reg, 12'b0}),
        .in_side  (p4_side_reg),
        .out_valid(dist_valid),
        .out_root (dist_root),
        .out_side (dist_side)
    );

    logic              s_valid_reg;
    logic [S_BITS-1:0] s_sum_reg;
    wt_side_t          s_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (advance)
            s_valid_reg <= dist_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s_sum_reg  <= S_BITS'(dist_root) + S_BITS'(kappa_reg);
            s_side_reg <= dist_side;
        end
    end

    // reciprocal of s, then its root
    logic                inv_valid;
    logic [INV_BITS-1:0] inv_quo;
    wt_side_t            inv_side;

    hawc_div_pipe #(
        .DW(S_BITS),
        .QW(INV_BITS),
        .SW($bits(wt_side_t))
    ) u_inv_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (s_valid_reg),
        .in_num   (INV_NUM),
        .in_den   (s_sum_reg),
        .in_side  (s_side_reg),
        .out_valid(inv_valid),
        .out_quo  (inv_quo),
        .out_side (inv_side)
    );

    logic              w_valid;
    logic [W_BITS-1:0] w_root;
    wt_side_t          w_side;

    hawc_sqrt_pipe #(
        .RW(INV_RAD_BITS),
        .SW($bits(wt_side_t))
    ) u_wt_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (inv_valid),
        .in_rad   ({1'b0, inv_quo}),
        .in_side  (inv_side),
        .out_valid(w_valid),
        .out_root (w_root),
        .out_side (w_side)
    );

    // saturate, fold, output register
    logic [W_BITS-1:0] w_sat;
    logic              do_fold;
    res_t              res_next;

    assign w_sat   = (w_root > WEIGHT_MAX) ? WEIGHT_MAX : w_root;
    assign do_fold = fold_reg && w_side.angle[15];

    always_comb
    begin
        res_next = '0;
        if (w_side.contributes)
        begin
            res_next.contributes = 1'b1;
            res_next.angle       = do_fold ? w_side.angle + PI_Q13 : w_side.angle;
            res_next.weight      = do_fold ? -$signed(w_sat) : $signed(w_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= w_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_data_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // checks
    a_no_contrib_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.contributes |-> res_data.angle == '0 && res_data.weight == '0)
        else $error("non-contributing beat carries nonzero angle or weight");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.contributes |->
            res_data.angle >= -PI_Q13 && res_data.angle <= PI_Q13)
        else $error("angle outside +-pi");

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid && div_side.contributes |-> div_quo <= RATIO_MAX)
        else $error("ratio divider quotient above one");

endmodule

/* rtl/core/hawc_div_pipe.sv */
module hawc_div_pipe #(
    parameter int DW = 20,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          valid_reg [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [SW-1:0] side_reg  [QW];
    logic [DW-1:0] rem_reg   [QW-1];
    logic [DW-1:0] den_reg   [QW-1];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic          v_in;
        logic [DW:0]   cur;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_in;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign cur     = {1'b0, in_num};
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[k-1];
            assign cur     = {rem_reg[k-1], 1'b0};
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign ge       = cur >= {1'b0, den_in};
        assign diff     = cur - {1'b0, den_in};
        assign rem_next = ge ? diff[DW-1:0] : cur[DW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k]  <= {quo_in[QW-2:0], ge};
                side_reg[k] <= side_in;
            end
        end

        if (k < QW - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

/* rtl/core/hawc_sqrt_pipe.sv */
module hawc_sqrt_pipe #(
    parameter int RW = 52,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [RW-1:0]   in_rad,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [RW/2-1:0] out_root,
    output logic [SW-1:0]   out_side
);

    localparam int HW = RW / 2;

    logic          valid_reg [HW];
    logic [HW-1:0] root_reg  [HW];
    logic [SW-1:0] side_reg  [HW];
    logic [HW-1:0] rem_reg   [HW-1];
    logic [RW-1:0] rad_reg   [HW-1];

    // one root bit per stage, two radicand bits consumed
    for (genvar k = 0; k < HW; k++)
    begin : g_stage
        logic          v_in;
        logic [HW-1:0] rem_in;
        logic [HW-1:0] root_in;
        logic [RW-1:0] rad_in;
        logic [SW-1:0] side_in;
        logic [HW+1:0] cur;
        logic [HW+1:0] trial;
        logic [HW+1:0] diff;
        logic          ge;
        logic [HW-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign cur      = {rem_in, rad_in[RW-1-2*k -: 2]};
        assign trial    = {root_in, 2'b01};
        assign ge       = cur >= trial;
        assign diff     = cur - trial;
        assign rem_next = ge ? diff[HW-1:0] : cur[HW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_in[HW-2:0], ge};
                side_reg[k] <= side_in;
            end
        end

        if (k < HW - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    rad_reg[k] <= rad_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[HW-1];
    assign out_root  = root_reg[HW-1];
    assign out_side  = side_reg[HW-1];

endmodule

/* tb/hit_angle_weight_contribution_test.sv */
`timescale 1ns / 100ps

module hit_angle_weight_contribution_test;
    import hawc_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     hit_valid;
    logic                     hit_stall;
    hit_t                     hit_data;
    logic                     res_valid;
    logic                     res_stall;
    res_t                     res_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    hit_angle_weight_contribution dut (
        .clk(clk), .rst_n(rst_n),
        .hit_valid(hit_valid), .hit_stall(hit_stall), .hit_data(hit_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hit_t pending_hits[$];
    res_t expected_results[$];

    logic [SHW_BITS-1:0]   model_half_width;
    logic [KAPPA_BITS-1:0] model_kappa;
    logic                  model_fold;

    int  errors;
    int  cycles;
    bit  hold_hits;
    int  hit_gap;
    int  res_gap;

    function automatic void add_pending(hit_t h);
        pending_hits.insert(pending_hits.size(), h);
    endfunction

    function automatic void add_expected(res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic res_t predict_contribution(hit_t h);
        longint dx, dz, ax, az, den, nmag, a, t, m, a16, ang, dist_q, s, w, wt;
        bit xneg, rneg;
        res_t r;
        r = '0;
        dx = longint'(h.hit_x) - longint'(h.vertex_x);
        dz = longint'(h.hit_z) - longint'(h.vertex_z);
        ax = dx < 0 ? -dx : dx;
        az = dz < 0 ? -dz : dz;
        if (ax > model_half_width || az > model_half_width || (ax == 0 && az == 0))
            return r;
        den = ax + az;
        xneg = dx < 0;
        if (xneg)
            rneg = az < ax;
        else
            rneg = ax < az;
        nmag = (ax > az) ? ax - az : az - ax;
        a = (nmag << 16) / den;
        t = (12865 * ((a * a) >> 16)) >> 16;
        m = ((64337 - t) * a) >> 16;
        a16 = xneg ? 154416 : 51472;
        a16 = rneg ? a16 + m : a16 - m;
        if (a16 < 0)
            a16 = 0;
        ang = (a16 + 4) >> 3;
        if (dz < 0)
            ang = -ang;
        dist_q = longint'(int_sqrt(64'(ax * ax + az * az) << 12));
        s = dist_q + model_kappa;
        w = longint'(int_sqrt((64'd1 << 60) / 64'(s)) >> 12);
        wt = w > 32767 ? 32767 : w;
        if (model_fold && ang < 0)
        begin
            ang += 25736;
            wt = -wt;
        end
        r.contributes = 1'b1;
        r.angle = 16'(ang);
        r.weight = 16'(wt);
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom);
    endfunction

    function automatic hit_t near_hit(int spread);
        hit_t h;
        h.vertex_x = rand_coord();
        h.vertex_z = rand_coord();
        h.hit_x = h.vertex_x + COORD_BITS'($urandom_range(2 * spread) - spread);
        h.hit_z = h.vertex_z + COORD_BITS'($urandom_range(2 * spread) - spread);
        return h;
    endfunction

    function automatic hit_t make_hit(int vx, int vz, int hx, int hz);
        hit_t h;
        h.vertex_x = COORD_BITS'(vx);
        h.vertex_z = COORD_BITS'(vz);
        h.hit_x = COORD_BITS'(hx);
        h.hit_z = COORD_BITS'(hz);
        return h;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hit driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_valid <= 1'b0;
            hit_data <= '0;
            hit_gap <= 0;
        end
        else if (!(hit_valid && hit_stall))
        begin
            if (hit_valid)
                add_expected(predict_contribution(hit_data));
            if (hit_gap > 0)
            begin
                hit_gap <= hit_gap - 1;
                hit_valid <= 1'b0;
            end
            else if (!hold_hits && pending_hits.size() > 0)
            begin
                hit_valid <= 1'b1;
                hit_data <= pending_hits.pop_front();
                if ($urandom_range(3) == 0)
                    hit_gap <= ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(3);
            end
            else
                hit_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            res_gap <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected beat %p", $time, res_data);
                    errors++;
                end
                else
                begin
                    res_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (res_data.contributes !== exp_res.contributes)
                    begin
                        $display("%0t: contributes expected %0d actual %0d", $time,
                                 exp_res.contributes, res_data.contributes);
                        errors++;
                    end
                    if (res_data.angle !== exp_res.angle)
                    begin
                        $display("%0t: angle expected %0d actual %0d", $time,
                                 exp_res.angle, res_data.angle);
                        errors++;
                    end
                    if (res_data.weight !== exp_res.weight)
                    begin
                        $display("%0t: weight expected %0d actual %0d", $time,
                                 exp_res.weight, res_data.weight);
                        errors++;
                    end
                end
            end
            if (res_gap > 0)
            begin
                res_gap <= res_gap - 1;
                res_stall <= 1'b1;
            end
            else if ($urandom_range(4) == 0)
            begin
                res_gap <= ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(3);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_BITS'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SEARCH_HALF_WIDTH: model_half_width = SHW_BITS'(value);
            CFG_KAPPA:             model_kappa = KAPPA_BITS'(value);
            CFG_FOLD_ENABLE:       model_fold = value[0];
            default:               ;
        endcase
    endtask

    task automatic drain();
        hold_hits = 1'b0;
        while (pending_hits.size() > 0 || hit_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        hold_hits = 1'b1;
    endtask

    task automatic queue_random(int count, int spread);
        hit_t h;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0:       h = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                1:       h = near_hit(3);
                default: h = near_hit(spread);
            endcase
            add_pending(h);
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_hits = 1'b1;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SEARCH_HALF_WIDTH;
        cfg_data = '0;
        model_half_width = SHW_RESET;
        model_kappa = KAPPA_RESET;
        model_fold = FOLD_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings
        add_pending(make_hit(0, 0, 0, 0));
        add_pending(make_hit(100, -100, 100, -100));
        add_pending(make_hit(0, 0, 50, 0));
        add_pending(make_hit(0, 0, -50, 0));
        add_pending(make_hit(0, 0, 0, 50));
        add_pending(make_hit(0, 0, 0, -50));
        add_pending(make_hit(0, 0, -30, -70));
        add_pending(make_hit(0, 0, 40, -10));
        add_pending(make_hit(0, 0, 6400, 6400));
        add_pending(make_hit(0, 0, -6400, -6400));
        add_pending(make_hit(0, 0, 6401, 0));
        add_pending(make_hit(0, 0, 0, -6401));
        add_pending(make_hit(0, 0, 1, 1));
        add_pending(make_hit(-524288, -524288, 524287, 524287));
        add_pending(make_hit(524287, 524287, -524288, -524288));
        add_pending(make_hit(-524288, 524287, -524288, 524287));
        queue_random(60, 8000);
        drain();

        // widest window, zero kappa, no folding
        write_reg(CFG_SEARCH_HALF_WIDTH, 524287);
        write_reg(CFG_KAPPA, 0);
        write_reg(CFG_FOLD_ENABLE, 0);
        add_pending(make_hit(0, 0, 1, 0));
        add_pending(make_hit(0, 0, 0, -1));
        add_pending(make_hit(0, 0, -1, -1));
        add_pending(make_hit(-524288, -524288, 524287, 524287));
        add_pending(make_hit(262143, 0, -262144, -1));
        queue_random(120, 300000);
        drain();

        // zero window, max kappa, folding
        write_reg(CFG_SEARCH_HALF_WIDTH, 0);
        write_reg(CFG_KAPPA, 65535);
        write_reg(CFG_FOLD_ENABLE, 1);
        queue_random(30, 2);
        drain();

        // small window, folding on
        write_reg(CFG_SEARCH_HALF_WIDTH, 1);
        write_reg(CFG_KAPPA, 1);
        queue_random(40, 2);
        drain();

        // random settings
        for (int phase = 0; phase < 4; phase++)
        begin
            int hw;
            hw = $urandom_range(1, 524287);
            write_reg(CFG_SEARCH_HALF_WIDTH, hw);
            write_reg(CFG_KAPPA, $urandom_range(65535));
            write_reg(CFG_FOLD_ENABLE, $urandom_range(1));
            queue_random(65, hw + hw / 8 + 2);
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
